/* sv/ihp_pkg.sv */
// Shared types, constants and the character classifier of the IPv4/TCP hex header parser.
`default_nettype none

package ihp_pkg;

  // Largest header window that is captured, and the width of any byte count.
  localparam int unsigned MaxHeaderBytes = 64;
  localparam int unsigned CntW = 7;

  // Character codes of the hex text.
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;
  localparam logic [7:0] CharLowA  = 8'h61;
  localparam logic [7:0] CharLowF  = 8'h66;
  localparam logic [7:0] CharUpA   = 8'h41;
  localparam logic [7:0] CharUpF   = 8'h46;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] HexLetterBase = 8'd10;

  // Byte positions of the IPv4 fields and the shortest acceptable line.
  localparam logic [CntW-1:0] ByteLenFirst = CntW'(2);
  localparam logic [CntW-1:0] ByteLenLast  = CntW'(3);
  localparam logic [CntW-1:0] ByteSrcFirst = CntW'(12);
  localparam logic [CntW-1:0] ByteSrcLast  = CntW'(15);
  localparam logic [CntW-1:0] ByteDstFirst = CntW'(16);
  localparam logic [CntW-1:0] ByteDstLast  = CntW'(19);
  localparam logic [CntW-1:0] MinLineBytes = CntW'(20);
  localparam logic [CntW-1:0] PortBytes    = CntW'(4);

  typedef enum logic [1:0] {
    TOK_NIBBLE,
    TOK_SPACE,
    TOK_BAD
  } tok_kind_e;

  typedef struct packed {
    tok_kind_e  kind;
    logic [3:0] nibble;
    logic       eol;
  } token_t;

  typedef struct packed {
    logic [15:0] total_length;
    logic [31:0] source_address;
    logic [31:0] destination_address;
    logic [15:0] source_port;
    logic [15:0] destination_port;
    logic        format_error;
  } result_t;

  // Turns one character into a token: a nibble value, a space or a bad character.
  function automatic token_t classify(logic [7:0] code, logic eol);
    token_t     tok;
    logic [7:0] diff;
    tok.kind   = TOK_BAD;
    tok.nibble = 4'h0;
    tok.eol    = eol;
    diff       = 8'h00;
    priority if (code >= CharZero && code <= CharNine) begin
      tok.kind   = TOK_NIBBLE;
      tok.nibble = code[3:0];
    end else if (code >= CharLowA && code <= CharLowF) begin
      diff       = code - CharLowA + HexLetterBase;
      tok.kind   = TOK_NIBBLE;
      tok.nibble = diff[3:0];
    end else if (code >= CharUpA && code <= CharUpF) begin
      diff       = code - CharUpA + HexLetterBase;
      tok.kind   = TOK_NIBBLE;
      tok.nibble = diff[3:0];
    end else if (code == CharSpace) begin
      tok.kind = TOK_SPACE;
    end else begin
      tok.kind = TOK_BAD;
    end
    return tok;
  endfunction

endpackage

`default_nettype wire

/* sv/ihp_front.sv */
// Front end: classifies incoming characters and holds them in a two-entry token queue.
`default_nettype none

module ihp_front
  import ihp_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   push_i,
  input  wire logic [7:0] char_code_i,
  input  wire logic   end_of_line_i,
  output logic        full_o,
  output logic        tok_valid_o,
  output token_t      tok_o,
  input  wire logic   tok_pop_i
);

  token_t     mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push_ok, pop_ok;

  assign full_o      = (cnt_q == 2'd2);
  assign tok_valid_o = (cnt_q != 2'd0);
  assign tok_o       = mem_q[rd_ptr_q];
  assign push_ok     = push_i && !full_o;
  assign pop_ok      = tok_pop_i && tok_valid_o;

  always_comb begin
    wr_ptr_d = push_ok ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_ok ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, push_ok} - {1'b0, pop_ok};
  end

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      mem_q[wr_ptr_q] <= classify(char_code_i, end_of_line_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

`default_nettype wire

/* sv/ihp_back.sv */
// Back end: pairs nibbles into bytes, captures the header fields and queues line results.
`default_nettype none

module ihp_back
  import ihp_pkg::*;
#(
  parameter int unsigned MAX_HEADER_BYTES = MaxHeaderBytes
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   tok_valid_i,
  input  wire token_t tok_i,
  output logic        tok_pop_o,
  input  wire logic   pop_i,
  output logic        empty_o,
  output result_t     res_o
);

  localparam int unsigned IdxW = $clog2(MAX_HEADER_BYTES + 1);
  localparam logic [IdxW-1:0] IdxMax = IdxW'(MAX_HEADER_BYTES);

  // Line state.
  logic            nib_pend_q, nib_pend_d;
  logic [3:0]      hi_nib_q, hi_nib_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [5:0]      hb_q, hb_d;
  logic [15:0]     len_q, len_d;
  logic [31:0]     src_q, src_d;
  logic [31:0]     dst_q, dst_d;
  logic [15:0]     sp_q, sp_d;
  logic [15:0]     dp_q, dp_d;
  logic            err_q, err_d;

  // Values after the current token, before the end-of-line clear.
  logic            u_nib_pend;
  logic [3:0]      u_hi_nib;
  logic [IdxW-1:0] u_idx;
  logic [5:0]      u_hb;
  logic [15:0]     u_len, u_sp, u_dp;
  logic [31:0]     u_src, u_dst;
  logic            u_err;

  logic [7:0]      byte_val;
  logic [CntW-1:0] idx_w, hb_w, rel, needed;
  logic            take, emit;
  result_t         res_new;

  // Result queue.
  result_t    rq_q [2];
  logic       rq_wr_q, rq_wr_d;
  logic       rq_rd_q, rq_rd_d;
  logic [1:0] rq_cnt_q, rq_cnt_d;
  logic       rq_pop;

  assign tok_pop_o = tok_valid_i && (!tok_i.eol || (rq_cnt_q != 2'd2));
  assign take      = tok_pop_o;
  assign emit      = take && tok_i.eol;
  assign byte_val  = {hi_nib_q, tok_i.nibble};
  assign idx_w     = CntW'(idx_q);

  always_comb begin
    u_nib_pend = nib_pend_q;
    u_hi_nib   = hi_nib_q;
    u_idx      = idx_q;
    u_hb       = hb_q;
    u_len      = len_q;
    u_src      = src_q;
    u_dst      = dst_q;
    u_sp       = sp_q;
    u_dp       = dp_q;
    u_err      = err_q;
    hb_w       = CntW'(hb_q);
    rel        = '0;
    unique case (tok_i.kind)
      TOK_NIBBLE: begin
        if (nib_pend_q) begin
          u_nib_pend = 1'b0;
          if (idx_q < IdxMax) begin
            if (idx_w == '0) begin
              u_hb = {byte_val[3:0], 2'b00};
            end
            hb_w = CntW'(u_hb);
            if (idx_w == ByteLenFirst || idx_w == ByteLenLast) begin
              u_len = {len_q[7:0], byte_val};
            end
            if (idx_w >= ByteSrcFirst && idx_w <= ByteSrcLast) begin
              u_src = {src_q[23:0], byte_val};
            end
            if (idx_w >= ByteDstFirst && idx_w <= ByteDstLast) begin
              u_dst = {dst_q[23:0], byte_val};
            end
            if (idx_w >= hb_w) begin
              rel = idx_w - hb_w;
              if (rel < CntW'(2)) begin
                u_sp = {sp_q[7:0], byte_val};
              end else if (rel < PortBytes) begin
                u_dp = {dp_q[7:0], byte_val};
              end
            end
            u_idx = idx_q + IdxW'(1);
          end
        end else begin
          u_hi_nib   = tok_i.nibble;
          u_nib_pend = 1'b1;
        end
      end
      TOK_SPACE: begin
      end
      TOK_BAD: begin
        u_err = 1'b1;
      end
      default: begin
        u_err = 1'b1;
      end
    endcase
  end

  // Line verdict: the ports must lie inside the line, and the line must reach the addresses.
  always_comb begin
    needed = CntW'(u_hb) + PortBytes;
    if (needed < MinLineBytes) begin
      needed = MinLineBytes;
    end
    res_new.total_length        = u_len;
    res_new.source_address      = u_src;
    res_new.destination_address = u_dst;
    res_new.source_port         = u_sp;
    res_new.destination_port    = u_dp;
    res_new.format_error        = u_err || u_nib_pend || (CntW'(u_idx) < needed);
  end

  always_comb begin
    nib_pend_d = nib_pend_q;
    hi_nib_d   = hi_nib_q;
    idx_d      = idx_q;
    hb_d       = hb_q;
    len_d      = len_q;
    src_d      = src_q;
    dst_d      = dst_q;
    sp_d       = sp_q;
    dp_d       = dp_q;
    err_d      = err_q;
    if (emit) begin
      nib_pend_d = 1'b0;
      hi_nib_d   = '0;
      idx_d      = '0;
      hb_d       = '0;
      len_d      = '0;
      src_d      = '0;
      dst_d      = '0;
      sp_d       = '0;
      dp_d       = '0;
      err_d      = 1'b0;
    end else if (take) begin
      nib_pend_d = u_nib_pend;
      hi_nib_d   = u_hi_nib;
      idx_d      = u_idx;
      hb_d       = u_hb;
      len_d      = u_len;
      src_d      = u_src;
      dst_d      = u_dst;
      sp_d       = u_sp;
      dp_d       = u_dp;
      err_d      = u_err;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nib_pend_q <= 1'b0;
      hi_nib_q   <= '0;
      idx_q      <= '0;
      hb_q       <= '0;
      len_q      <= '0;
      src_q      <= '0;
      dst_q      <= '0;
      sp_q       <= '0;
      dp_q       <= '0;
      err_q      <= 1'b0;
    end else begin
      nib_pend_q <= nib_pend_d;
      hi_nib_q   <= hi_nib_d;
      idx_q      <= idx_d;
      hb_q       <= hb_d;
      len_q      <= len_d;
      src_q      <= src_d;
      dst_q      <= dst_d;
      sp_q       <= sp_d;
      dp_q       <= dp_d;
      err_q      <= err_d;
    end
  end

  assign empty_o = (rq_cnt_q == 2'd0);
  assign res_o   = rq_q[rq_rd_q];
  assign rq_pop  = pop_i && !empty_o;

  always_comb begin
    rq_wr_d  = emit ? ~rq_wr_q : rq_wr_q;
    rq_rd_d  = rq_pop ? ~rq_rd_q : rq_rd_q;
    rq_cnt_d = rq_cnt_q + {1'b0, emit} - {1'b0, rq_pop};
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      rq_q[rq_wr_q] <= res_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rq_wr_q  <= 1'b0;
      rq_rd_q  <= 1'b0;
      rq_cnt_q <= 2'd0;
    end else begin
      rq_wr_q  <= rq_wr_d;
      rq_rd_q  <= rq_rd_d;
      rq_cnt_q <= rq_cnt_d;
    end
  end

endmodule

`default_nettype wire

/* sv/ipv4_tcp_header_hex_parser.sv */
// Top level of the IPv4/TCP header parser that reads packet bytes written as hex text.
`default_nettype none

// This block reads one line of hex text, one character per transaction, and
// reports the IPv4 total length, the source and destination addresses and the
// TCP source and destination ports of the packet that the line spells out.
// Spaces are skipped, hex digits of either case pair into bytes high nibble
// first, and the port offset follows the IHL nibble of the first byte. The
// character pushed with end_of_line_i set closes the line: exactly one result
// transaction follows it, and all capture state clears for the next line. Any
// other character, an odd number of digits, or a line too short to hold the
// addresses and the ports raises format_error_o, while the fields still show
// whatever was captured (zero for bytes never reached). Bytes at index
// MAX_HEADER_BYTES and beyond are ignored. The block takes one character per
// clock cycle while full is low; a character is held in the character queue
// before it reaches the byte assembler, and the result of a line is held in the
// result queue until it is popped. A two-entry character queue and a two-entry
// result queue let the input keep flowing while a result waits to be popped;
// full only rises when the result queue is full and an end-of-line character waits.
module ipv4_tcp_header_hex_parser
  import ihp_pkg::*;
#(
  parameter int unsigned MAX_HEADER_BYTES = MaxHeaderBytes
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  char_code_i,
  input  wire logic        end_of_line_i,
  output logic             empty,
  input  wire logic        pop,
  output logic [15:0]      total_length_o,
  output logic [31:0]      source_address_o,
  output logic [31:0]      destination_address_o,
  output logic [15:0]      source_port_o,
  output logic [15:0]      destination_port_o,
  output logic             format_error_o
);

  // Tokens travel from the classifier to the byte assembler through this queue.
  logic    tok_valid;
  logic    tok_pop;
  token_t  tok;
  result_t res;

  ihp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .char_code_i  (char_code_i),
    .end_of_line_i(end_of_line_i),
    .full_o       (full),
    .tok_valid_o  (tok_valid),
    .tok_o        (tok),
    .tok_pop_i    (tok_pop)
  );

  ihp_back #(
    .MAX_HEADER_BYTES(MAX_HEADER_BYTES)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .tok_valid_i(tok_valid),
    .tok_i      (tok),
    .tok_pop_o  (tok_pop),
    .pop_i      (pop),
    .empty_o    (empty),
    .res_o      (res)
  );

  // The oldest queued result drives the result ports.
  assign total_length_o        = res.total_length;
  assign source_address_o      = res.source_address;
  assign destination_address_o = res.destination_address;
  assign source_port_o         = res.source_port;
  assign destination_port_o    = res.destination_port;
  assign format_error_o        = res.format_error;

endmodule

`default_nettype wire

/* sv/ihp_checker.sv */
// Port-level assertions for the hex header parser and the bind that attaches them.
`default_nettype none

module ihp_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        push,
  input wire logic        full,
  input wire logic [7:0]  char_code_i,
  input wire logic        end_of_line_i,
  input wire logic        empty,
  input wire logic        pop,
  input wire logic [15:0] total_length_o,
  input wire logic [31:0] source_address_o,
  input wire logic [31:0] destination_address_o,
  input wire logic [15:0] source_port_o,
  input wire logic [15:0] destination_port_o,
  input wire logic        format_error_o
);

  // A waiting result stays put until it is popped.
  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(total_length_o) && $stable(source_address_o)
      && $stable(destination_address_o) && $stable(source_port_o)
      && $stable(destination_port_o) && $stable(format_error_o)))
    else $error("result changed or vanished before it was popped");

  // The character queue only fills through a push.
  a_full_needs_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!full && !push) |=> !full)
    else $error("queue became full without a push");

  // Reset leaves both queues empty.
  a_reset_state: assert property (@(posedge clk_i)
    !rst_ni |=> (empty && !full))
    else $error("queues not empty after reset");

  // A result cannot appear in the cycle right after an idle, empty block.
  a_no_spurious_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (empty && !full && !push && $past(empty) && !$past(push) && $past(rst_ni)
      && !$past(full)) |=> (empty || $past(push, 1) || $past(push, 2)))
    else $error("result appeared without any pushed line");

endmodule

bind ipv4_tcp_header_hex_parser ihp_checker u_ihp_checker (.*);

`default_nettype wire
